### src/mpmc_pkg.sv
package mpmc_pkg;

    // trie sizing
    localparam int MAX_NODES     = 4096;
    localparam int ALPHABET_SIZE = 26;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int CNT_W         = $clog2(MAX_NODES + 1);
    localparam int SYM_W         = 5;
    localparam int TOTAL_W       = 16;
    localparam int CHILD_DEPTH   = MAX_NODES * ALPHABET_SIZE;
    localparam int CHILD_AW      = $clog2(CHILD_DEPTH);
    localparam logic [TOTAL_W-1:0] CNT_MAX = '1;

    // operation codes on the input tuser
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_BUILD  = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    // result codes on the output tuser
    typedef enum logic [1:0] {
        KIND_STORED   = 2'd0,
        KIND_BUILT    = 2'd1,
        KIND_TOTAL    = 2'd2,
        KIND_OVERFLOW = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CHK,
        ST_INS_CLR,
        ST_INS_LAST,
        ST_INS_ACC,
        ST_BLD_POP,
        ST_BLD_POPW,
        ST_BLD_CRD,
        ST_BLD_CHK,
        ST_BLD_FX,
        ST_BLD_YLD,
        ST_BLD_YRD,
        ST_BLD_YCHK,
        ST_BLD_YF,
        ST_BLD_SET,
        ST_SRC_RD,
        ST_SRC_CHK,
        ST_SRC_FW,
        ST_SRC_ARD,
        ST_SRC_ACC,
        ST_SRC_LAST,
        ST_EMIT
    } state_t;

    // flat child table address of (node, letter)
    function automatic logic [CHILD_AW-1:0] child_addr(input logic [NODE_W-1:0] node,
                                                       input logic [SYM_W-1:0] sym);
        child_addr = CHILD_AW'(node) * CHILD_AW'(ALPHABET_SIZE) + CHILD_AW'(sym);
    endfunction

    // 16-bit saturating add
    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[TOTAL_W] ? CNT_MAX : s[TOTAL_W-1:0];
    endfunction

endpackage

### src/mpmc_ram.sv
module mpmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### src/multi_pattern_match_counter_core.sv
// Aho-Corasick keyword counter over a 26-letter alphabet with a 4096-node trie. Every
// operation runs on a small sequencer around one single-port read of the child table,
// so s_axis_tready is high only between operations. After reset, and after a clear,
// the root row is wiped one letter slot at a time. An insert character looks up the
// child and, when there is none, allocates a node and wipes its row; the pattern's last
// character then counts the pattern end, and a pool overflow is reported instead. A
// build dequeues each node, reads its letter slots, links each child of the root to the
// root and follows the failure chain of the parent for each deeper child. A search
// character probes the goto entry, follows a failure link on each miss, then collects
// and clears the counts on the output chain; the text's last character emits the total.
// A result waits in an output register, and the next transaction is accepted while
// it is pending; a second result holds the sequencer until the first is taken.
module multi_pattern_match_counter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] symbol, [7:5] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] func
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] match_total
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    localparam int NW = mpmc_pkg::NODE_W;
    localparam int CW = mpmc_pkg::CNT_W;
    localparam int SW = mpmc_pkg::SYM_W;
    localparam int TW = mpmc_pkg::TOTAL_W;
    localparam int AW = mpmc_pkg::CHILD_AW;

    mpmc_pkg::state_t state_reg, state_next;

    logic [SW-1:0] sym_reg, sym_next;
    logic          last_reg, last_next;
    logic [CW-1:0] nodes_used_reg, nodes_used_next;
    logic [NW-1:0] icur_reg, icur_next;
    logic [NW-1:0] scur_reg, scur_next;
    logic [TW-1:0] total_reg, total_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] head_reg, head_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [NW-1:0] node_a_reg, node_a_next;
    logic [NW-1:0] node_b_reg, node_b_next;
    logic [NW-1:0] node_y_reg, node_y_next;
    logic [SW-1:0] idx_reg, idx_next;
    logic [1:0]    res_kind_reg, res_kind_next;
    logic [TW-1:0] res_total_reg, res_total_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_kind_reg, out_kind_next;
    logic [TW-1:0] out_total_reg, out_total_next;

    // memory ports
    logic          ch_we;
    logic [AW-1:0] ch_waddr, ch_raddr;
    logic [NW-1:0] ch_wdata, ch_rdata;
    logic          fl_we;
    logic [NW-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;
    logic          hf_we;
    logic [NW-1:0] hf_waddr, hf_raddr;
    logic          hf_wdata, hf_rdata;
    logic          acc_we;
    logic [NW-1:0] acc_waddr, acc_raddr;
    logic [TW-1:0] acc_wdata, acc_rdata;
    logic          q_we;
    logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

    logic s_acc;
    logic idx_end;

    assign s_axis_tready = (state_reg == mpmc_pkg::ST_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign idx_end       = (idx_reg == SW'(mpmc_pkg::ALPHABET_SIZE - 1));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_total_reg;
    assign m_axis_tuser  = out_kind_reg;

    // trie storage
    mpmc_ram #(.WIDTH(NW), .DEPTH(mpmc_pkg::CHILD_DEPTH)) u_child (
        .clk(clk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_rdata)
    );
    mpmc_ram #(.WIDTH(NW), .DEPTH(mpmc_pkg::MAX_NODES)) u_fail (
        .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
        .raddr(fl_raddr), .rdata(fl_rdata)
    );
    mpmc_ram #(.WIDTH(1), .DEPTH(mpmc_pkg::MAX_NODES)) u_hasfail (
        .clk(clk), .we(hf_we), .waddr(hf_waddr), .wdata(hf_wdata),
        .raddr(hf_raddr), .rdata(hf_rdata)
    );
    mpmc_ram #(.WIDTH(TW), .DEPTH(mpmc_pkg::MAX_NODES)) u_accept (
        .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
        .raddr(acc_raddr), .rdata(acc_rdata)
    );
    mpmc_ram #(.WIDTH(NW), .DEPTH(mpmc_pkg::MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mpmc_pkg::ST_INIT;
            nodes_used_reg <= CW'(1);
            icur_reg       <= '0;
            scur_reg       <= '0;
            total_reg      <= '0;
            drop_reg       <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nodes_used_reg <= nodes_used_next;
            icur_reg       <= icur_next;
            scur_reg       <= scur_next;
            total_reg      <= total_next;
            drop_reg       <= drop_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sym_reg       <= sym_next;
        last_reg      <= last_next;
        node_a_reg    <= node_a_next;
        node_b_reg    <= node_b_next;
        node_y_reg    <= node_y_next;
        res_kind_reg  <= res_kind_next;
        res_total_reg <= res_total_next;
        out_kind_reg  <= out_kind_next;
        out_total_reg <= out_total_next;
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        sym_next        = sym_reg;
        last_next       = last_reg;
        nodes_used_next = nodes_used_reg;
        icur_next       = icur_reg;
        scur_next       = scur_reg;
        total_next      = total_reg;
        drop_next       = drop_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        node_a_next     = node_a_reg;
        node_b_next     = node_b_reg;
        node_y_next     = node_y_reg;
        idx_next        = idx_reg;
        res_kind_next   = res_kind_reg;
        res_total_next  = res_total_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_total_next  = out_total_reg;

        ch_we     = 1'b0;
        ch_waddr  = mpmc_pkg::child_addr(node_b_reg, idx_reg);
        ch_wdata  = '0;
        ch_raddr  = mpmc_pkg::child_addr(node_a_reg, idx_reg);
        fl_we     = 1'b0;
        fl_waddr  = node_b_reg;
        fl_wdata  = node_y_reg;
        fl_raddr  = node_a_reg;
        hf_we     = 1'b0;
        hf_waddr  = node_b_reg;
        hf_wdata  = 1'b0;
        hf_raddr  = node_a_reg;
        acc_we    = 1'b0;
        acc_waddr = node_b_reg;
        acc_wdata = '0;
        acc_raddr = icur_reg;
        q_we      = 1'b0;
        q_waddr   = tail_reg[NW-1:0];
        q_wdata   = node_b_reg;
        q_raddr   = head_reg[NW-1:0];

        unique case (state_reg)
            // wipe the root row
            mpmc_pkg::ST_INIT:
            begin
                ch_we    = 1'b1;
                ch_waddr = mpmc_pkg::child_addr('0, idx_reg);
                if (idx_reg == '0)
                begin
                    acc_we    = 1'b1;
                    acc_waddr = '0;
                    hf_we     = 1'b1;
                    hf_waddr  = '0;
                end
                if (idx_end)
                begin
                    idx_next   = '0;
                    state_next = mpmc_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end

            // take a transaction and dispatch
            mpmc_pkg::ST_IDLE:
            begin
                if (s_acc)
                begin
                    sym_next  = s_axis_tdata[SW-1:0];
                    last_next = s_axis_tlast;
                    unique case (mpmc_pkg::func_t'(s_axis_tuser))
                        mpmc_pkg::FUNC_CLEAR:
                        begin
                            nodes_used_next = CW'(1);
                            icur_next       = '0;
                            scur_next       = '0;
                            total_next      = '0;
                            drop_next       = 1'b0;
                            idx_next        = '0;
                            state_next      = mpmc_pkg::ST_INIT;
                        end
                        mpmc_pkg::FUNC_BUILD:
                        begin
                            q_we       = 1'b1;
                            q_waddr    = '0;
                            q_wdata    = '0;
                            head_next  = '0;
                            tail_next  = CW'(1);
                            state_next = mpmc_pkg::ST_BLD_POP;
                        end
                        mpmc_pkg::FUNC_INSERT:
                        begin
                            if (drop_reg)
                            begin
                                if (s_axis_tlast)
                                begin
                                    drop_next = 1'b0;
                                end
                            end
                            else if (s_axis_tdata[SW-1:0] < SW'(mpmc_pkg::ALPHABET_SIZE))
                            begin
                                state_next = mpmc_pkg::ST_INS_RD;
                            end
                            else
                            begin
                                state_next = mpmc_pkg::ST_INS_LAST;
                            end
                        end
                        mpmc_pkg::FUNC_SEARCH:
                        begin
                            if (s_axis_tdata[SW-1:0] < SW'(mpmc_pkg::ALPHABET_SIZE))
                            begin
                                node_a_next = scur_reg;
                                state_next  = mpmc_pkg::ST_SRC_RD;
                            end
                            else
                            begin
                                scur_next  = '0;
                                state_next = mpmc_pkg::ST_SRC_LAST;
                            end
                        end
                        default:
                        begin
                            state_next = mpmc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            // insert: look up the child
            mpmc_pkg::ST_INS_RD:
            begin
                ch_raddr   = mpmc_pkg::child_addr(icur_reg, sym_reg);
                state_next = mpmc_pkg::ST_INS_CHK;
            end

            mpmc_pkg::ST_INS_CHK:
            begin
                if (ch_rdata != '0)
                begin
                    icur_next  = ch_rdata;
                    state_next = mpmc_pkg::ST_INS_LAST;
                end
                else if (nodes_used_reg == CW'(mpmc_pkg::MAX_NODES))
                begin
                    icur_next      = '0;
                    drop_next      = !last_reg;
                    res_kind_next  = mpmc_pkg::KIND_OVERFLOW;
                    res_total_next = '0;
                    state_next     = mpmc_pkg::ST_EMIT;
                end
                else
                begin
                    ch_we           = 1'b1;
                    ch_waddr        = mpmc_pkg::child_addr(icur_reg, sym_reg);
                    ch_wdata        = nodes_used_reg[NW-1:0];
                    node_b_next     = nodes_used_reg[NW-1:0];
                    icur_next       = nodes_used_reg[NW-1:0];
                    nodes_used_next = nodes_used_reg + CW'(1);
                    idx_next        = '0;
                    state_next      = mpmc_pkg::ST_INS_CLR;
                end
            end

            // insert: wipe the new node's row
            mpmc_pkg::ST_INS_CLR:
            begin
                ch_we = 1'b1;
                if (idx_reg == '0)
                begin
                    acc_we = 1'b1;
                    hf_we  = 1'b1;
                end
                if (idx_end)
                begin
                    idx_next   = '0;
                    state_next = mpmc_pkg::ST_INS_LAST;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end

            mpmc_pkg::ST_INS_LAST:
            begin
                acc_raddr  = icur_reg;
                state_next = last_reg ? mpmc_pkg::ST_INS_ACC : mpmc_pkg::ST_IDLE;
            end

            // insert: count the pattern end
            mpmc_pkg::ST_INS_ACC:
            begin
                acc_we         = 1'b1;
                acc_waddr      = icur_reg;
                acc_wdata      = mpmc_pkg::sat_add(acc_rdata, TW'(1));
                icur_next      = '0;
                res_kind_next  = mpmc_pkg::KIND_STORED;
                res_total_next = '0;
                state_next     = mpmc_pkg::ST_EMIT;
            end

            // build: dequeue a node
            mpmc_pkg::ST_BLD_POP:
            begin
                q_raddr = head_reg[NW-1:0];
                if (head_reg < tail_reg)
                begin
                    state_next = mpmc_pkg::ST_BLD_POPW;
                end
                else
                begin
                    icur_next      = '0;
                    scur_next      = '0;
                    total_next     = '0;
                    drop_next      = 1'b0;
                    res_kind_next  = mpmc_pkg::KIND_BUILT;
                    res_total_next = '0;
                    state_next     = mpmc_pkg::ST_EMIT;
                end
            end

            mpmc_pkg::ST_BLD_POPW:
            begin
                node_a_next = q_rdata;
                head_next   = head_reg + CW'(1);
                idx_next    = '0;
                state_next  = mpmc_pkg::ST_BLD_CRD;
            end

            mpmc_pkg::ST_BLD_CRD:
            begin
                ch_raddr   = mpmc_pkg::child_addr(node_a_reg, idx_reg);
                state_next = mpmc_pkg::ST_BLD_CHK;
            end

            mpmc_pkg::ST_BLD_CHK:
            begin
                if (ch_rdata == '0)
                begin
                    if (idx_end)
                    begin
                        state_next = mpmc_pkg::ST_BLD_POP;
                    end
                    else
                    begin
                        idx_next   = idx_reg + SW'(1);
                        state_next = mpmc_pkg::ST_BLD_CRD;
                    end
                end
                else
                begin
                    node_b_next = ch_rdata;
                    if (node_a_reg == '0)
                    begin
                        node_y_next = '0;
                        state_next  = mpmc_pkg::ST_BLD_SET;
                    end
                    else
                    begin
                        state_next = mpmc_pkg::ST_BLD_FX;
                    end
                end
            end

            // build: follow failure links of the parent
            mpmc_pkg::ST_BLD_FX:
            begin
                fl_raddr   = node_a_reg;
                state_next = mpmc_pkg::ST_BLD_YLD;
            end

            mpmc_pkg::ST_BLD_YLD:
            begin
                node_y_next = fl_rdata;
                state_next  = mpmc_pkg::ST_BLD_YRD;
            end

            mpmc_pkg::ST_BLD_YRD:
            begin
                ch_raddr   = mpmc_pkg::child_addr(node_y_reg, idx_reg);
                state_next = mpmc_pkg::ST_BLD_YCHK;
            end

            mpmc_pkg::ST_BLD_YCHK:
            begin
                if (ch_rdata != '0)
                begin
                    node_y_next = ch_rdata;
                    state_next  = mpmc_pkg::ST_BLD_SET;
                end
                else
                begin
                    fl_raddr   = node_y_reg;
                    hf_raddr   = node_y_reg;
                    state_next = mpmc_pkg::ST_BLD_YF;
                end
            end

            mpmc_pkg::ST_BLD_YF:
            begin
                if (!hf_rdata)
                begin
                    node_y_next = '0;
                    state_next  = mpmc_pkg::ST_BLD_SET;
                end
                else
                begin
                    node_y_next = fl_rdata;
                    state_next  = mpmc_pkg::ST_BLD_YRD;
                end
            end

            // build: store the link and enqueue the child
            mpmc_pkg::ST_BLD_SET:
            begin
                fl_we    = 1'b1;
                hf_we    = 1'b1;
                hf_wdata = 1'b1;
                if (tail_reg < CW'(mpmc_pkg::MAX_NODES))
                begin
                    q_we      = 1'b1;
                    tail_next = tail_reg + CW'(1);
                end
                if (idx_end)
                begin
                    state_next = mpmc_pkg::ST_BLD_POP;
                end
                else
                begin
                    idx_next   = idx_reg + SW'(1);
                    state_next = mpmc_pkg::ST_BLD_CRD;
                end
            end

            // search: goto / failure walk
            mpmc_pkg::ST_SRC_RD:
            begin
                ch_raddr   = mpmc_pkg::child_addr(node_a_reg, sym_reg);
                state_next = mpmc_pkg::ST_SRC_CHK;
            end

            mpmc_pkg::ST_SRC_CHK:
            begin
                if (ch_rdata != '0)
                begin
                    node_y_next = ch_rdata;
                    scur_next   = ch_rdata;
                    state_next  = mpmc_pkg::ST_SRC_ARD;
                end
                else
                begin
                    fl_raddr   = node_a_reg;
                    hf_raddr   = node_a_reg;
                    state_next = mpmc_pkg::ST_SRC_FW;
                end
            end

            mpmc_pkg::ST_SRC_FW:
            begin
                if (!hf_rdata)
                begin
                    scur_next  = '0;
                    state_next = mpmc_pkg::ST_SRC_LAST;
                end
                else
                begin
                    node_a_next = fl_rdata;
                    state_next  = mpmc_pkg::ST_SRC_RD;
                end
            end

            // search: collect and clear counts along the output chain
            mpmc_pkg::ST_SRC_ARD:
            begin
                acc_raddr  = node_y_reg;
                hf_raddr   = node_y_reg;
                fl_raddr   = node_y_reg;
                state_next = mpmc_pkg::ST_SRC_ACC;
            end

            mpmc_pkg::ST_SRC_ACC:
            begin
                total_next = mpmc_pkg::sat_add(total_reg, acc_rdata);
                acc_we     = 1'b1;
                acc_waddr  = node_y_reg;
                if (hf_rdata)
                begin
                    node_y_next = fl_rdata;
                    state_next  = mpmc_pkg::ST_SRC_ARD;
                end
                else
                begin
                    state_next = mpmc_pkg::ST_SRC_LAST;
                end
            end

            mpmc_pkg::ST_SRC_LAST:
            begin
                if (last_reg)
                begin
                    res_kind_next  = mpmc_pkg::KIND_TOTAL;
                    res_total_next = total_reg;
                    total_next     = '0;
                    scur_next      = '0;
                    state_next     = mpmc_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = mpmc_pkg::ST_IDLE;
                end
            end

            // hand the result to the output register
            mpmc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = res_kind_reg;
                    out_total_next = res_total_reg;
                    state_next     = mpmc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mpmc_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // node pool count stays within the root and the pool size
    assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg != '0 && nodes_used_reg <= CW'(mpmc_pkg::MAX_NODES))
        else $error("node count out of range");

    // build queue head never passes the tail
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mpmc_pkg::ST_BLD_POPW) |-> (head_reg < tail_reg))
        else $error("build queue underflow");

    // every accepted transaction other than an insert character starts work
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && s_axis_tuser != mpmc_pkg::FUNC_INSERT) |=>
        (state_reg != mpmc_pkg::ST_IDLE))
        else $error("transaction ignored");

    // result register is never overwritten while pending
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> (out_valid_reg && $stable(out_total_reg)))
        else $error("pending result lost");
`endif

endmodule

### test/multi_pattern_match_counter_core_tb.sv
`timescale 1ns / 100ps

module multi_pattern_match_counter_core_tb;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int PHASE_ITEMS   = 350;
    localparam int DRAIN_CYCLES  = 300;
    localparam int NUM_DIRECTED  = 24;
    localparam int NODES         = mpmc_pkg::MAX_NODES;
    localparam int ALPHA         = mpmc_pkg::ALPHABET_SIZE;
    localparam int NW            = mpmc_pkg::NODE_W;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    multi_pattern_match_counter_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // one expected result transaction
    typedef struct packed {
        mpmc_pkg::kind_t kind;
        logic [15:0]     total;
    } match_result_t;

    // one row of the directed stimulus
    typedef struct {
        mpmc_pkg::func_t func;
        logic [4:0]      symbol;
        logic            last;
        bit              typed;
        mpmc_pkg::kind_t kind;
        logic [15:0]     total;
    } stim_row_t;

    match_result_t pending_results[$];

    // trie mirror
    logic [NW-1:0] trie_kid [NODES*ALPHA];
    logic [NW-1:0] trie_fail [NODES];
    bit            trie_hasfail [NODES];
    int unsigned   trie_acc [NODES];
    int unsigned   bfs_order [NODES];
    int unsigned   trie_used;
    int unsigned   ins_node;
    int unsigned   srch_node;
    int unsigned   srch_sum;
    bit            ins_skip;

    int          tx_idle_pct;
    int          rx_stall_pct;
    int          hold_request;
    int          hold_left;
    int          cycle_count;
    int          mismatch_count;
    int          items_sent;
    int          results_seen;
    int          overflow_seen;
    int          nonzero_totals;

    // dictionary of the current session
    int unsigned pat_sym [8][16];
    int          pat_len [8];
    int          pat_count;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned kid_of(int unsigned node, int unsigned sym);
        if (node >= NODES || sym >= ALPHA)
            return 0;
        return trie_kid[node*ALPHA + sym];
    endfunction

    function automatic void wipe_node(int unsigned node);
        for (int i = 0; i < ALPHA; i++)
            trie_kid[node*ALPHA + i] = '0;
        trie_hasfail[node] = 1'b0;
        trie_acc[node]     = 0;
        trie_fail[node]    = '0;
    endfunction

    function automatic void empty_trie();
        wipe_node(0);
        trie_used = 1;
        ins_node  = 0;
        srch_node = 0;
        srch_sum  = 0;
        ins_skip  = 1'b0;
    endfunction

    // breadth-first failure link computation
    function automatic void link_failures();
        int unsigned head;
        int unsigned tail;
        int unsigned x;
        int unsigned c;
        int unsigned y;
        int unsigned guard;
        bit ok;
        head = 0;
        tail = 1;
        bfs_order[0] = 0;
        while (head < tail && head < NODES)
        begin
            x = bfs_order[head];
            head++;
            for (int i = 0; i < ALPHA; i++)
            begin
                c = kid_of(x, i);
                if (c == 0)
                    continue;
                if (x == 0)
                begin
                    trie_fail[c] = '0;
                end
                else
                begin
                    y = trie_fail[x];
                    ok = trie_hasfail[x];
                    guard = 0;
                    while (ok && kid_of(y, i) == 0 && guard < NODES)
                    begin
                        ok = trie_hasfail[y];
                        y = trie_fail[y];
                        guard++;
                    end
                    trie_fail[c] = (ok && kid_of(y, i) != 0) ? NW'(kid_of(y, i)) : '0;
                end
                trie_hasfail[c] = 1'b1;
                if (tail < NODES)
                begin
                    bfs_order[tail] = c;
                    tail++;
                end
            end
        end
        ins_node  = 0;
        srch_node = 0;
        srch_sum  = 0;
        ins_skip  = 1'b0;
    endfunction

    // advance the mirror by one input transaction, returns 1 when a result is due
    function automatic bit predict_match(mpmc_pkg::func_t func, logic [4:0] symbol,
                                         logic last, output match_result_t res);
        int unsigned c;
        int unsigned x;
        int unsigned y;
        int unsigned guard;
        bit ok;
        bit more;
        res = '{mpmc_pkg::KIND_STORED, 16'd0};
        case (func)
            mpmc_pkg::FUNC_CLEAR:
            begin
                empty_trie();
                return 1'b0;
            end
            mpmc_pkg::FUNC_BUILD:
            begin
                link_failures();
                res.kind = mpmc_pkg::KIND_BUILT;
                return 1'b1;
            end
            mpmc_pkg::FUNC_INSERT:
            begin
                if (ins_skip)
                begin
                    if (last)
                        ins_skip = 1'b0;
                    return 1'b0;
                end
                if (symbol < ALPHA)
                begin
                    c = kid_of(ins_node, symbol);
                    if (c == 0)
                    begin
                        // node pool exhausted
                        if (trie_used >= NODES)
                        begin
                            ins_node = 0;
                            if (!last)
                                ins_skip = 1'b1;
                            res.kind = mpmc_pkg::KIND_OVERFLOW;
                            return 1'b1;
                        end
                        c = trie_used;
                        trie_used++;
                        wipe_node(c);
                        trie_kid[ins_node*ALPHA + symbol] = NW'(c);
                    end
                    ins_node = c;
                end
                if (!last)
                    return 1'b0;
                if (trie_acc[ins_node] < 65535)
                    trie_acc[ins_node]++;
                ins_node = 0;
                res.kind = mpmc_pkg::KIND_STORED;
                return 1'b1;
            end
            default:
            begin
                x = srch_node;
                ok = 1'b1;
                guard = 0;
                while (ok && kid_of(x, symbol) == 0 && guard < NODES)
                begin
                    ok = trie_hasfail[x];
                    x = trie_fail[x];
                    guard++;
                end
                if (!ok || kid_of(x, symbol) == 0)
                begin
                    srch_node = 0;
                end
                else
                begin
                    // collect along the output chain
                    y = kid_of(x, symbol);
                    srch_node = y;
                    more = 1'b1;
                    guard = 0;
                    while (more && guard <= NODES)
                    begin
                        srch_sum += trie_acc[y];
                        if (srch_sum > 65535)
                            srch_sum = 65535;
                        trie_acc[y] = 0;
                        more = trie_hasfail[y];
                        y = trie_fail[y];
                        guard++;
                    end
                end
                if (!last)
                    return 1'b0;
                res.kind  = mpmc_pkg::KIND_TOTAL;
                res.total = 16'(srch_sum);
                srch_sum  = 0;
                srch_node = 0;
                return 1'b1;
            end
        endcase
    endfunction

    // drive one transaction and wait for its handshake
    task automatic send_item(mpmc_pkg::func_t func, logic [4:0] symbol, logic last,
                             bit typed = 1'b0, match_result_t typed_res = '0);
        match_result_t res;
        bit due;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, symbol};
        s_axis_tuser  <= func;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
        due = predict_match(func, symbol, last, res);
        if (typed)
            pending_results.push_back(typed_res);
        else if (due)
            pending_results.push_back(res);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // random symbol, mostly in the alphabet
    function automatic logic [4:0] pick_symbol(int span);
        if ($urandom_range(49) == 0)
            return 5'($urandom_range(31, ALPHA));
        return 5'($urandom_range(span - 1));
    endfunction

    task automatic send_pattern(int p);
        for (int j = 0; j < pat_len[p]; j++)
            send_item(mpmc_pkg::FUNC_INSERT, 5'(pat_sym[p][j]), j == pat_len[p] - 1);
    endtask

    // one dictionary, an optional build and several texts, plus some noise
    task automatic run_session();
        int span;
        int texts;
        int n;
        int p;
        int q;
        logic [4:0] text_sym [$];
        send_item(mpmc_pkg::FUNC_CLEAR, 5'($urandom_range(31)), 1'($urandom_range(1)));
        case ($urandom_range(2))
            0: span = 2;
            1: span = 4;
            default: span = ALPHA;
        endcase
        pat_count = $urandom_range(6, 1);
        for (int i = 0; i < pat_count; i++)
        begin
            pat_len[i] = $urandom_range(5, 1);
            for (int j = 0; j < pat_len[i]; j++)
                pat_sym[i][j] = pick_symbol(span);
            send_pattern(i);
        end
        if ($urandom_range(9) != 0)
            send_item(mpmc_pkg::FUNC_BUILD, 5'($urandom_range(31)), 1'($urandom_range(1)));
        texts = $urandom_range(5, 1);
        for (int t = 0; t < texts; t++)
        begin
            text_sym.delete();
            n = $urandom_range(6, 1);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(1))
                begin
                    p = $urandom_range(pat_count - 1);
                    for (int j = 0; j < pat_len[p]; j++)
                        text_sym.push_back(5'(pat_sym[p][j]));
                end
                else
                begin
                    text_sym.push_back(pick_symbol(span));
                end
            end
            for (int j = 0; j < text_sym.size(); j++)
                send_item(mpmc_pkg::FUNC_SEARCH, text_sym[j], j == text_sym.size() - 1);
            // noise between texts
            if ($urandom_range(3) == 0)
            begin
                q = $urandom_range(3, 1);
                for (int j = 0; j < q; j++)
                    send_item(mpmc_pkg::func_t'($urandom_range(3)), 5'($urandom_range(31)),
                              1'($urandom_range(1)));
            end
        end
    endtask

    // receiver readiness, with one long hold-off at the start of the first random phase
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        match_result_t exp_res;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: kind %0d total %0d",
                             m_axis_tuser, m_axis_tdata);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (exp_res.kind == mpmc_pkg::KIND_OVERFLOW)
                    overflow_seen++;
                if (exp_res.kind == mpmc_pkg::KIND_TOTAL && exp_res.total != 0)
                    nonzero_totals++;
                if (m_axis_tuser !== exp_res.kind || m_axis_tdata !== exp_res.total)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected kind %0d total %0d, got %0d total %0d",
                                 exp_res.kind, exp_res.total, m_axis_tuser, m_axis_tdata);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        stim_row_t dir_rows [NUM_DIRECTED];
        int ptr;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        tx_idle_pct   = 0;
        rx_stall_pct  = 0;
        hold_request  = 0;
        cycle_count   = 0;
        mismatch_count = 0;
        items_sent    = 0;
        results_seen  = 0;
        overflow_seen = 0;
        nonzero_totals = 0;
        empty_trie();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: empty trie, classic keyword set, edge letters
        dir_rows = '{
            '{mpmc_pkg::FUNC_SEARCH, 5'd0,  1'b1, 1'b1, mpmc_pkg::KIND_TOTAL,  16'd0},
            '{mpmc_pkg::FUNC_BUILD,  5'd31, 1'b0, 1'b1, mpmc_pkg::KIND_BUILT,  16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd7,  1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd4,  1'b1, 1'b1, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd18, 1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd7,  1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd4,  1'b1, 1'b1, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd7,  1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd4,  1'b1, 1'b1, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd31, 1'b1, 1'b1, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd0,  1'b1, 1'b1, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd25, 1'b1, 1'b1, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_BUILD,  5'd0,  1'b1, 1'b1, mpmc_pkg::KIND_BUILT,  16'd0},
            '{mpmc_pkg::FUNC_SEARCH, 5'd20, 1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_SEARCH, 5'd18, 1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_SEARCH, 5'd7,  1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_SEARCH, 5'd4,  1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_SEARCH, 5'd26, 1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_SEARCH, 5'd25, 1'b1, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_CLEAR,  5'd31, 1'b1, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd0,  1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_INSERT, 5'd1,  1'b1, 1'b1, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_SEARCH, 5'd0,  1'b0, 1'b0, mpmc_pkg::KIND_STORED, 16'd0},
            '{mpmc_pkg::FUNC_SEARCH, 5'd1,  1'b1, 1'b0, mpmc_pkg::KIND_STORED, 16'd0}
        };
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(dir_rows[i].func, dir_rows[i].symbol, dir_rows[i].last,
                      dir_rows[i].typed, '{dir_rows[i].kind, dir_rows[i].total});
        wait_drained();

        // random sessions under four idling profiles
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 52;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 52;
                end
                default:
                begin
                    tx_idle_pct  = 24;
                    rx_stall_pct = 24;
                end
            endcase
            ptr = items_sent;
            if (phase == 0)
                hold_request = 400;
            while (items_sent - ptr < PHASE_ITEMS)
                run_session();
            wait_drained();
        end

        $display("%0d input transactions, %0d result transactions in %0d cycles",
                 items_sent, results_seen, cycle_count);
        $display("%0d search totals above zero, %0d pool overflows, mismatches %0d",
                 nonzero_totals, overflow_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### multi_pattern_match_counter_core.f
src/mpmc_pkg.sv
src/mpmc_ram.sv
src/multi_pattern_match_counter_core.sv
test/multi_pattern_match_counter_core_tb.sv
